// ===== rtl/tcq_pkg.sv =====
package tcq_pkg;

    // Ring geometry
    localparam int QUEUE_BYTES  = 64;
    localparam int IDX_W        = $clog2(QUEUE_BYTES);
    localparam int RECORD_BYTES = 5;

    // Byte positions inside one record
    localparam logic [2:0] REC_HZ_LO  = 3'd0;
    localparam logic [2:0] REC_HZ_HI  = 3'd1;
    localparam logic [2:0] REC_VOL    = 3'd2;
    localparam logic [2:0] REC_MS_LO  = 3'd3;
    localparam logic [2:0] REC_MS_HI  = 3'd4;
    localparam int         SEL_W      = 3;

    // Commands
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Result kinds chosen by the controller
    localparam logic [1:0] OUT_ENQ_OK    = 2'd0;
    localparam logic [1:0] OUT_ENQ_FULL  = 2'd1;
    localparam logic [1:0] OUT_DEQ_OK    = 2'd2;
    localparam logic [1:0] OUT_DEQ_EMPTY = 2'd3;

    // Divider: 32-bit dividend (hz << 16), one quotient bit per cycle
    localparam int DVD_W     = 32;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = 5;

    // ms / 10 as (ms * 52429) >> 19, exact for any 16-bit ms
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam int          TICKS_W     = 13;

    localparam logic [15:0] SAMPLE_RATE_RST = 16'd19530;

    typedef struct packed {
        logic        command;
        logic [15:0] tone_hz;
        logic [15:0] duration_ms;
        logic [7:0]  volume_db;
    } t_in_word;

    typedef struct packed {
        logic               accepted;
        logic               loaded;
        logic [7:0]         step_int;
        logic [7:0]         step_frac;
        logic [7:0]         gain;
        logic [TICKS_W-1:0] duration_ticks;
        logic               tone_on;
    } t_out_word;

    // Controller -> datapath
    typedef struct packed {
        logic             load_in;
        logic             wr_en;
        logic [SEL_W-1:0] wr_sel;
        logic             rd_en;
        logic             cap_en;
        logic [SEL_W-1:0] cap_sel;
        logic             div_start;
        logic             div_step;
        logic             out_load;
        logic [1:0]       out_kind;
    } t_ctl;

    // Datapath -> controller
    typedef struct packed {
        logic deq;
        logic room;
        logic record;
    } t_sts;

    // floor(255 * 10^(-db/20)); bytes 128..255 count as 0 dB
    function automatic logic [7:0] gain_of(input logic [7:0] db);
        logic [7:0] g;
        case (db) inside
            8'd0:  g = 8'd255;
            8'd1:  g = 8'd227;
            8'd2:  g = 8'd202;
            8'd3:  g = 8'd180;
            8'd4:  g = 8'd160;
            8'd5:  g = 8'd143;
            8'd6:  g = 8'd127;
            8'd7:  g = 8'd113;
            8'd8:  g = 8'd101;
            8'd9:  g = 8'd90;
            8'd10: g = 8'd80;
            8'd11: g = 8'd71;
            8'd12: g = 8'd64;
            8'd13: g = 8'd57;
            8'd14: g = 8'd50;
            8'd15: g = 8'd45;
            8'd16: g = 8'd40;
            8'd17: g = 8'd36;
            8'd18: g = 8'd32;
            8'd19: g = 8'd28;
            8'd20: g = 8'd25;
            8'd21: g = 8'd22;
            8'd22: g = 8'd20;
            8'd23: g = 8'd18;
            8'd24: g = 8'd16;
            8'd25: g = 8'd14;
            8'd26: g = 8'd12;
            8'd27: g = 8'd11;
            8'd28: g = 8'd10;
            8'd29: g = 8'd9;
            8'd30: g = 8'd8;
            8'd31: g = 8'd7;
            8'd32: g = 8'd6;
            [8'd33:8'd34]:  g = 8'd5;
            [8'd35:8'd36]:  g = 8'd4;
            [8'd37:8'd38]:  g = 8'd3;
            [8'd39:8'd42]:  g = 8'd2;
            [8'd43:8'd48]:  g = 8'd1;
            [8'd49:8'd127]: g = 8'd0;
            default:        g = 8'd255;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/tcq_ram.sv =====
module tcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcq_dp.sv =====
module tcq_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcq_pkg::t_in_word  i_in_word,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  tcq_pkg::t_ctl      i_ctl,
    output tcq_pkg::t_sts      o_sts,
    output tcq_pkg::t_out_word o_out_word
);

    localparam int IDX_W = tcq_pkg::IDX_W;

    tcq_pkg::t_in_word  r_word;
    tcq_pkg::t_out_word r_out;
    tcq_pkg::t_out_word n_out;

    logic [15:0]      r_sample_rate;
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic [15:0]      r_hz;
    logic [7:0]       r_vol;
    logic [15:0]      r_ms;

    logic [tcq_pkg::DVD_W-1:0] r_dvd;
    logic [15:0]               r_rem;
    logic [15:0]               r_quo;

    logic [IDX_W:0]   used;
    logic [7:0]       wdata;
    logic [7:0]       rdata;
    logic [15:0]      div_sr;
    logic [16:0]      rem_sh;
    logic [16:0]      rem_diff;
    logic             q_bit;
    logic [31:0]      ms_prod;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(tcq_pkg::QUEUE_BYTES - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Bytes in use
    always_comb begin
        if (r_wr_idx >= r_rd_idx) begin
            used = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
        end else begin
            used = {1'b0, r_wr_idx} + (IDX_W+1)'(tcq_pkg::QUEUE_BYTES) - {1'b0, r_rd_idx};
        end
    end

    assign o_sts.deq    = (r_word.command == tcq_pkg::CMD_DEQUEUE);
    assign o_sts.room   = (used <= (IDX_W+1)'(tcq_pkg::QUEUE_BYTES - 1 - tcq_pkg::RECORD_BYTES));
    assign o_sts.record = (used >= (IDX_W+1)'(tcq_pkg::RECORD_BYTES));

    // Record byte to write
    always_comb begin
        case (i_ctl.wr_sel)
            tcq_pkg::REC_HZ_LO: wdata = r_word.tone_hz[7:0];
            tcq_pkg::REC_HZ_HI: wdata = r_word.tone_hz[15:8];
            tcq_pkg::REC_VOL:   wdata = r_word.volume_db;
            tcq_pkg::REC_MS_LO: wdata = r_word.duration_ms[7:0];
            tcq_pkg::REC_MS_HI: wdata = r_word.duration_ms[15:8];
            default:            wdata = '0;
        endcase
    end

    tcq_ram #(
        .WIDTH (8),
        .DEPTH (tcq_pkg::QUEUE_BYTES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (r_wr_idx),
        .i_wdata (wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (rdata)
    );

    // Restoring divider step; a zero rate divides by one
    assign div_sr   = (r_sample_rate == 16'd0) ? 16'd1 : r_sample_rate;
    assign rem_sh   = {r_rem, r_dvd[tcq_pkg::DVD_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, div_sr});
    assign rem_diff = rem_sh - {1'b0, div_sr};

    assign ms_prod = 32'(r_ms) * 32'(tcq_pkg::DIV10_MUL);

    always_comb begin
        n_out = '0;
        case (i_ctl.out_kind)
            tcq_pkg::OUT_ENQ_OK: begin
                n_out.accepted = 1'b1;
            end
            tcq_pkg::OUT_DEQ_OK: begin
                n_out.loaded         = 1'b1;
                n_out.step_int       = r_quo[15:8];
                n_out.step_frac      = r_quo[7:0];
                n_out.gain           = tcq_pkg::gain_of(r_vol);
                n_out.duration_ticks = ms_prod[tcq_pkg::DIV10_SHIFT +: tcq_pkg::TICKS_W];
                n_out.tone_on        = (r_hz != 16'd0);
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= tcq_pkg::SAMPLE_RATE_RST;
            r_wr_idx      <= '0;
            r_rd_idx      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sample_rate <= i_cfg_data;
            end
            if (i_ctl.wr_en) begin
                r_wr_idx <= ring_next(r_wr_idx);
            end
            if (i_ctl.rd_en) begin
                r_rd_idx <= ring_next(r_rd_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_word <= i_in_word;
        end
        if (i_ctl.cap_en) begin
            case (i_ctl.cap_sel)
                tcq_pkg::REC_HZ_LO: r_hz[7:0]  <= rdata;
                tcq_pkg::REC_HZ_HI: r_hz[15:8] <= rdata;
                tcq_pkg::REC_VOL:   r_vol      <= rdata;
                tcq_pkg::REC_MS_LO: r_ms[7:0]  <= rdata;
                tcq_pkg::REC_MS_HI: r_ms[15:8] <= rdata;
                default:            r_vol      <= r_vol;
            endcase
        end
        if (i_ctl.div_start) begin
            r_dvd <= {r_hz, 16'd0};
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_ctl.div_step) begin
            r_dvd <= {r_dvd[tcq_pkg::DVD_W-2:0], 1'b0};
            r_rem <= q_bit ? rem_diff[15:0] : rem_sh[15:0];
            r_quo <= {r_quo[14:0], q_bit};
        end
        if (i_ctl.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_word = r_out;

endmodule

// ===== rtl/tcq_ctrl.sv =====
module tcq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  tcq_pkg::t_sts i_sts,
    output tcq_pkg::t_ctl o_ctl
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_WRITE    = 3'd2;
    localparam logic [2:0] ST_READ     = 3'd3;
    localparam logic [2:0] ST_DIV      = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    localparam int CNT_W = tcq_pkg::CNT_W;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_kind, n_kind;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_cnt = '0;
                if (i_sts.deq) begin
                    if (i_sts.record) begin
                        n_state = ST_READ;
                    end else begin
                        n_kind  = tcq_pkg::OUT_DEQ_EMPTY;
                        n_state = ST_FINISH;
                    end
                end else begin
                    if (i_sts.room) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_kind  = tcq_pkg::OUT_ENQ_FULL;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_WRITE: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = r_cnt[tcq_pkg::SEL_W-1:0];
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(tcq_pkg::RECORD_BYTES - 1)) begin
                    n_kind  = tcq_pkg::OUT_ENQ_OK;
                    n_state = ST_FINISH;
                end
            end
            ST_READ: begin
                // read data lands in the cycle after the address
                if (r_cnt < CNT_W'(tcq_pkg::RECORD_BYTES)) begin
                    o_ctl.rd_en = 1'b1;
                end
                if (r_cnt != '0) begin
                    o_ctl.cap_en  = 1'b1;
                    o_ctl.cap_sel = tcq_pkg::SEL_W'(r_cnt - 1'b1);
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(tcq_pkg::RECORD_BYTES)) begin
                    o_ctl.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(tcq_pkg::DIV_STEPS - 1)) begin
                    n_kind  = tcq_pkg::OUT_DEQ_OK;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_kind = r_kind;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_kind      <= tcq_pkg::OUT_ENQ_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/tone_command_queue_dds_setup.sv =====
// Tone command queue and DDS setup. Input words either enqueue a tone
// (hz, volume in dB, duration in ms) as a five-byte record into a 64-byte
// ring, or, on a timer tick, dequeue one whole record and return the DDS
// settings: phase step floor(hz*65536/sample_rate) mod 65536 as integer and
// fraction bytes, linear gain floor(255*10^(-dB/20)) (volume bytes 128..255
// give 255), duration in 10 ms ticks, and tone-on for nonzero hz. Every input
// word yields exactly one output word. An enqueue with fewer than five free
// bytes is refused (accepted = 0, ring untouched); a dequeue with fewer than
// five bytes in use returns all zeros. Timing: one word at a time. A refused
// or empty command goes from accept through dispatch to the result, a stored
// enqueue adds five single-port ring writes, and a dequeue adds ring reads
// through the registered RAM port and a one-bit-per-cycle restoring divider.
// The input is stalled while a word is in work; the result sits in an output
// register, so a new word is taken while an earlier result still waits on
// output stall. A result can only leave the block once the previous one has
// been taken. The sample rate register (reset 19530, zero acts as one) is
// written through i_cfg_we and i_cfg_data; the user must write it only while
// the block is idle, the block itself does not enforce this. Ring contents
// need no reset: only bytes already written are ever read.
module tone_command_queue_dds_setup_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command words in
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcq_pkg::t_in_word  i_in_word,
    // setting words out
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcq_pkg::t_out_word o_out_word,
    // sample rate register
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);

    tcq_pkg::t_ctl ctl;
    tcq_pkg::t_sts sts;

    // sequencing: accept, dispatch, ring access, divide, result hand-off
    tcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // ring, indices, divider, gain table and output register
    tcq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule
